FILE: rtl/bgd_pkg.sv
// ============================================================================
// bgd_pkg: shared types and constants of the button gesture detector
// Gesture code layout, tick counter limits, register map and channel types.
// ============================================================================
`default_nettype none

package bgd_pkg;

  // Number of joystick ports that keep gesture state.
  localparam int unsigned NUM_PORTS = 2;
  // Inputs per port: stick, trigger A, trigger B.
  localparam int unsigned NUM_INPUTS = 3;

  localparam int unsigned CODE_W = 5;
  localparam int unsigned TICK_W = 8;
  localparam int unsigned RAW_W  = 6;

  // Phase field, code bits [1:0].
  localparam logic [1:0] PH_OFF     = 2'd0;
  localparam logic [1:0] PH_PRESS   = 2'd1;
  localparam logic [1:0] PH_ON      = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Hold mark field, code bits [3:2].
  localparam logic [1:0] HM_NONE    = 2'd0;
  localparam logic [1:0] HM_HOLD    = 2'd1;
  localparam logic [1:0] HM_HOLDING = 2'd2;

  // Whole codes: the off code, and the codes that raise an event flag.
  localparam logic [CODE_W-1:0] CODE_OFF         = 5'h00;
  localparam logic [CODE_W-1:0] CODE_CLICK       = 5'h01;
  localparam logic [CODE_W-1:0] CODE_RELEASE     = 5'h03;
  localparam logic [CODE_W-1:0] CODE_HOLD        = 5'h06;
  localparam logic [CODE_W-1:0] CODE_DOUBLE      = 5'h11;
  localparam logic [CODE_W-1:0] CODE_DOUBLE_HOLD = 5'h16;

  localparam logic [TICK_W-1:0] TICK_MAX = 8'hFF;
  localparam logic [RAW_W-1:0]  RAW_IDLE = 6'h3F;

  localparam logic [TICK_W-1:0] HOLD_TIME_RST   = 8'h10;
  localparam logic [TICK_W-1:0] DBL_TIME_RST    = 8'h04;

  // Register index, taken from paddr[2].
  localparam logic REG_HOLD_TIME = 1'b0;
  localparam logic REG_DBL_TIME  = 1'b1;

  // Gesture state of one input.
  typedef struct packed {
    logic              dbl;
    logic [1:0]        hold_mark;
    logic [1:0]        phase;
    logic [TICK_W-1:0] ticks;
  } bgd_chan_t;

  // Timing limits handed to every gesture update unit.
  typedef struct packed {
    logic [TICK_W-1:0] hold_time;
    logic [TICK_W-1:0] dbl_time;
  } bgd_cfg_t;

endpackage : bgd_pkg

`default_nettype wire

FILE: rtl/bgd_gesture.sv
// ============================================================================
// bgd_gesture: next-state logic of one input's gesture tracker
// Advances the tick counter, steps the phase and marks, then applies edges.
// ============================================================================
`default_nettype none

module bgd_gesture (
  input  var bgd_pkg::bgd_cfg_t  cfg_i,
  input  wire logic              cur_on_i,
  input  wire logic              prev_on_i,
  input  var bgd_pkg::bgd_chan_t chan_i,
  output bgd_pkg::bgd_chan_t     chan_o
);
  import bgd_pkg::*;

  always_comb begin
    logic [TICK_W-1:0] t;
    bgd_chan_t         s;

    s = chan_i;
    t = (chan_i.ticks != TICK_MAX) ? chan_i.ticks + TICK_W'(1) : chan_i.ticks;

    // At most one phase or mark change per frame.
    if (s.phase == PH_PRESS) begin
      s.phase = PH_ON;
    end else if (s.phase == PH_RELEASE) begin
      s.phase     = PH_OFF;
      s.hold_mark = HM_NONE;
    end else if (s.hold_mark == HM_NONE && s.phase == PH_ON && t > cfg_i.hold_time) begin
      s.hold_mark = HM_HOLD;
    end else if (s.hold_mark == HM_HOLD) begin
      s.hold_mark = HM_HOLDING;
    end else if (s.phase == PH_OFF && t > cfg_i.dbl_time) begin
      s.dbl = 1'b0;
    end

    // A new press keeps the hold mark and may set the double mark; a new release clears both marks.
    if (cur_on_i && !prev_on_i) begin
      s.phase = PH_PRESS;
      if (t <= cfg_i.dbl_time) begin
        s.dbl = 1'b1;
      end
      t = '0;
    end else if (!cur_on_i && prev_on_i) begin
      s.dbl       = 1'b0;
      s.hold_mark = HM_NONE;
      s.phase     = PH_RELEASE;
      t           = '0;
    end

    s.ticks = t;
    chan_o  = s;
  end

endmodule : bgd_gesture

`default_nettype wire

FILE: rtl/button_gesture_detector_core.sv
// ============================================================================
// button_gesture_detector_core: click, hold and double-click detector
// Tracks stick, trigger A and trigger B of each joystick port per frame.
// ============================================================================
// Path: an accepted sample is held in the input register, then its result is
//   written to the result register; either step can stall on back-pressure.
// Throughput: one transaction per cycle while the output side flows, set by the
//   combinational gesture update between the input and result registers.
// Reset: all codes clear to off, tick counters saturate at 255, the previous
//   samples read as released, and the registers return to 16 and 4.
`default_nettype none

module button_gesture_detector_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Sample stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [5:0] raw_status, [7:6] zero
  input  wire logic        s_axis_tuser,   // [0] port
  // Gesture stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [4:0] stick_code, [9:5] button_a_code,
                                           // [14:10] button_b_code, [17:15] click_flags,
                                           // [20:18] release_flags, [23:21] hold_flags,
                                           // [26:24] double_click_flags,
                                           // [29:27] double_hold_flags, [31:30] zero
  output logic             m_axis_tuser,   // [0] port_out
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bgd_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers. paddr[2] picks the register, low bits are the
  // byte offset inside the word.
  // --------------------------------------------------------------------------
  bgd_cfg_t cfg_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time <= HOLD_TIME_RST;
      cfg_q.dbl_time  <= DBL_TIME_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_HOLD_TIME: cfg_q.hold_time <= pwdata[TICK_W-1:0];
        REG_DBL_TIME:  cfg_q.dbl_time  <= pwdata[TICK_W-1:0];
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HOLD_TIME: prdata = {24'd0, cfg_q.hold_time};
      REG_DBL_TIME:  prdata = {24'd0, cfg_q.dbl_time};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register moves into the result register whenever the
  // result register is empty or its transaction is taken in the same cycle,
  // so a new sample is accepted every cycle while the output side flows.
  // --------------------------------------------------------------------------
  logic             in_valid_q;
  logic             in_port_q;
  logic [RAW_W-1:0] in_raw_q;
  logic             out_valid_q;
  logic             out_free;
  logic             advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_port_q <= s_axis_tuser;
      in_raw_q  <= s_axis_tdata[RAW_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Gesture state: one tracker per input and port, plus the last sample of
  // each port so that press and release edges can be seen.
  // --------------------------------------------------------------------------
  bgd_chan_t        chan_q [NUM_PORTS][NUM_INPUTS];
  logic [RAW_W-1:0] prev_raw_q [NUM_PORTS];
  bgd_chan_t        chan_cur [NUM_INPUTS];
  bgd_chan_t        chan_nxt [NUM_INPUTS];
  logic [NUM_INPUTS-1:0] cur_on;
  logic [NUM_INPUTS-1:0] prev_on;
  logic [RAW_W-1:0] prev_raw;
  logic             port_ok;

  assign port_ok  = 32'(in_port_q) < NUM_PORTS;
  assign prev_raw = prev_raw_q[in_port_q];

  // The stick is on while any direction bit is low; triggers are active low.
  assign cur_on  = {!in_raw_q[5], !in_raw_q[4], (in_raw_q[3:0] != 4'hF)};
  assign prev_on = {!prev_raw[5], !prev_raw[4], (prev_raw[3:0] != 4'hF)};

  for (genvar k = 0; k < NUM_INPUTS; k++) begin : g_input
    assign chan_cur[k] = chan_q[in_port_q][k];

    bgd_gesture u_gesture (
      .cfg_i     (cfg_q),
      .cur_on_i  (cur_on[k]),
      .prev_on_i (prev_on[k]),
      .chan_i    (chan_cur[k]),
      .chan_o    (chan_nxt[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        prev_raw_q[p] <= RAW_IDLE;
        for (int k = 0; k < NUM_INPUTS; k++) begin
          chan_q[p][k] <= '{dbl: 1'b0, hold_mark: HM_NONE, phase: PH_OFF,
                            ticks: TICK_MAX};
        end
      end
    end else if (advance && port_ok) begin
      prev_raw_q[in_port_q] <= in_raw_q;
      for (int k = 0; k < NUM_INPUTS; k++) begin
        chan_q[in_port_q][k] <= chan_nxt[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result assembly. An out-of-range port reports all codes and flags as zero.
  // --------------------------------------------------------------------------
  logic [CODE_W-1:0]     code [NUM_INPUTS];
  logic [NUM_INPUTS-1:0] fl_click, fl_release, fl_hold, fl_double, fl_dhold;
  logic [31:0]           result_d;
  logic [31:0]           result_q;
  logic                  port_out_q;

  always_comb begin
    for (int k = 0; k < NUM_INPUTS; k++) begin
      code[k]       = port_ok ? {chan_nxt[k].dbl, chan_nxt[k].hold_mark, chan_nxt[k].phase}
                              : CODE_OFF;
      fl_click[k]   = port_ok && (code[k] == CODE_CLICK);
      fl_release[k] = port_ok && (code[k] == CODE_RELEASE);
      fl_hold[k]    = port_ok && (code[k] == CODE_HOLD);
      fl_double[k]  = port_ok && (code[k] == CODE_DOUBLE);
      fl_dhold[k]   = port_ok && (code[k] == CODE_DOUBLE_HOLD);
    end
    result_d = {2'b00, fl_dhold, fl_double, fl_hold, fl_release, fl_click,
                code[2], code[1], code[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q   <= result_d;
      port_out_q <= in_port_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = result_q;
  assign m_axis_tuser  = port_out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("input side stalled with an empty input register");

  a_port_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (m_axis_tvalid && m_axis_tuser == $past(in_port_q)))
    else $error("result port does not match the advanced sample");

  a_press_seen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && port_ok && cur_on[0] && !prev_on[0]) |=> (m_axis_tdata[1:0] == PH_PRESS))
    else $error("stick press edge not reported as press");

  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[17:15] & m_axis_tdata[20:18]) == 3'b000 &&
                       (m_axis_tdata[17:15] & m_axis_tdata[26:24]) == 3'b000))
    else $error("one input reports two exclusive events");

endmodule : button_gesture_detector_core

`default_nettype wire
